@@ rtl/assert_macros.svh @@
// Assertion helpers for the palette texel decoder RTL.
// Simulation builds get concurrent assertions; synthesis builds (SYNTH) get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: clocked assertion failed");

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

@@ rtl/ptd_pkg.sv @@
`timescale 1ns / 1ps

package ptd_pkg;

    localparam int PALETTE_WORDS_DEF = 256;
    localparam int QUEUE_DEPTH_DEF   = 4;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    // Entry formats
    typedef enum logic [1:0] {
        FMT_5650 = 2'd0,
        FMT_5551 = 2'd1,
        FMT_4444 = 2'd2,
        FMT_RAW  = 2'd3
    } fmt_t;

    // Texel index widths
    typedef enum logic [1:0] {
        MODE_PAIR4 = 2'd0,
        MODE_IDX8  = 2'd1,
        MODE_IDX16 = 2'd2,
        MODE_IDX32 = 2'd3
    } idx_mode_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START  = 3'd0,
        CFG_SHIFT  = 3'd1,
        CFG_MASK   = 3'd2,
        CFG_FORMAT = 3'd3,
        CFG_MODE   = 3'd4
    } cfg_idx_t;

    // Work queued from front to back
    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_SINGLE = 2'd1,
        OP_PAIR   = 2'd2
    } op_kind_t;

    localparam logic [8:0]  START_RST  = 9'd0;
    localparam logic [4:0]  SHIFT_RST  = 5'd0;
    localparam logic [7:0]  MASK_RST   = 8'hFF;
    localparam logic [7:0]  ALPHA_FULL = 8'hFF;

    typedef struct packed {
        logic [7:0] addr;   // palette word address
        logic       hi;     // upper halfword select
        logic       ok;     // address inside the store
    } lookup_t;

    typedef struct packed {
        op_kind_t    kind;
        fmt_t        fmt;
        lookup_t     first;
        lookup_t     second;
        logic [31:0] wdata;
    } entry_t;

    // n-bit channel to 8 bits: (c+1)*255 >> n, zero stays zero
    function automatic logic [7:0] widen(input logic [5:0] c, input logic [2:0] n);
        logic [13:0] p;
        p = 14'(c) + 14'd1;
        p = (p << 8) - p;
        return (c == 6'd0) ? 8'd0 : 8'(p >> n);
    endfunction

    function automatic logic [31:0] expand(input logic [15:0] h, input fmt_t f);
        logic [7:0] a, r, g, b;
        case (f)
            FMT_5650:
            begin
                a = ALPHA_FULL;
                r = widen({1'b0, h[15:11]}, 3'd5);
                g = widen(h[10:5], 3'd6);
                b = widen({1'b0, h[4:0]}, 3'd5);
            end
            FMT_5551:
            begin
                a = h[15] ? ALPHA_FULL : 8'd0;
                r = widen({1'b0, h[14:10]}, 3'd5);
                g = widen({1'b0, h[9:5]}, 3'd5);
                b = widen({1'b0, h[4:0]}, 3'd5);
            end
            default:
            begin
                r = widen({2'b0, h[15:12]}, 3'd4);
                g = widen({2'b0, h[11:8]}, 3'd4);
                b = widen({2'b0, h[7:4]}, 3'd4);
                a = widen({2'b0, h[3:0]}, 3'd4);
            end
        endcase
        return {a, r, g, b};
    endfunction

endpackage

@@ rtl/palette_texel_decoder_unit.sv @@
`timescale 1ns / 1ps
// Palette texel decoder: color lookup table with expansion to 8888.
// Input stream (s_axis): tuser = 1 writes palette_word at palette_address into the
// palette store and gives no result; tuser = 0 decodes texel_data through the palette.
// Output stream (m_axis): one 32-bit color per palette index, tlast on the final
// result of an input transfer. 4-bit index mode gives two results (low nibble first).
// Configuration: cfg_we writes cfg_data into register cfg_index (0 start, 1 shift,
// 2 mask, 3 format, 4 index mode); write it only while the block is idle.
// Path: a decode result passes the queue register, the palette read register and the
// output register before it shows on m_axis_tvalid.
// Throughput: one input transfer per cycle while the queue has room; a 4-bit-mode item
// holds the palette read port for both of its reads and leaves the queue after the second.
// Reset: config registers return to start 0, shift 0, mask 0xFF, format 5650, 8-bit
// index; the queue and pipeline empty. Palette contents are undefined until written.
// Stall: when m_axis_tready is low the output register, the read stage and the
// work queue fill in turn, then s_axis_tready drops; nothing is lost or repeated.
module palette_texel_decoder_unit
    import ptd_pkg::*;
#(
    parameter int PALETTE_WORDS = PALETTE_WORDS_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [31:0] texel_data, [39:32] palette_address, [71:40] palette_word
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] action
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [31:0] color
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    logic   push;
    entry_t push_entry;
    logic   push_ready;
    logic   head_valid;
    entry_t head_entry;
    logic   pop;

    // Front: hold config, classify each transfer, form palette addresses
    ptd_front #(
        .PALETTE_WORDS (PALETTE_WORDS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push          (push),
        .push_entry    (push_entry),
        .push_ready    (push_ready)
    );

    // Queue: decouple the input side from palette access and output stalls
    ptd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop)
    );

    // Back: palette store access, color expansion, output register
    ptd_back #(
        .PALETTE_WORDS (PALETTE_WORDS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_entry    (head_entry),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

@@ rtl/ptd_ram.sv @@
`timescale 1ns / 1ps

module ptd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/ptd_front.sv @@
`timescale 1ns / 1ps

module ptd_front
    import ptd_pkg::*;
#(
    parameter int PALETTE_WORDS = PALETTE_WORDS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tuser,
    output logic                  push,
    output entry_t                push_entry,
    input  logic                  push_ready
);

    logic [8:0] start_reg;
    logic [4:0] shift_reg;
    logic [7:0] mask_reg;
    fmt_t       fmt_reg;
    idx_mode_t  mode_reg;

    logic [31:0] texel;
    logic [7:0]  waddr;
    logic [31:0] wdata;
    logic [31:0] idx0;
    logic [31:0] idx1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= START_RST;
            shift_reg <= SHIFT_RST;
            mask_reg  <= MASK_RST;
            fmt_reg   <= FMT_5650;
            mode_reg  <= MODE_IDX8;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START:  start_reg <= cfg_data;
                CFG_SHIFT:  shift_reg <= cfg_data[4:0];
                CFG_MASK:   mask_reg  <= cfg_data[7:0];
                CFG_FORMAT: fmt_reg   <= fmt_t'(cfg_data[1:0]);
                CFG_MODE:   mode_reg  <= idx_mode_t'(cfg_data[1:0]);
                default:    ;
            endcase
        end
    end

    function automatic logic in_store(input logic [7:0] a);
        return 32'(a) < 32'(PALETTE_WORDS);
    endfunction

    // Offset, shift and mask, then split into word address and halfword (RAW: whole word)
    function automatic lookup_t make_lookup(
        input logic [31:0] idx,
        input logic [8:0]  start,
        input logic [4:0]  shift,
        input logic [7:0]  mask,
        input fmt_t        fmt
    );
        logic [31:0] sum;
        logic [31:0] shifted;
        logic [7:0]  fi;
        lookup_t     lk;
        sum     = {23'd0, start} + idx;
        shifted = sum >> shift;
        fi      = shifted[7:0] & mask;
        if (fmt == FMT_RAW)
        begin
            lk.addr = fi;
            lk.hi   = 1'b0;
        end
        else
        begin
            lk.addr = {1'b0, fi[7:1]};
            lk.hi   = fi[0];
        end
        lk.ok = in_store(lk.addr);
        return lk;
    endfunction

    assign texel = s_axis_tdata[31:0];
    assign waddr = s_axis_tdata[39:32];
    assign wdata = s_axis_tdata[71:40];

    always_comb
    begin
        case (mode_reg)
            MODE_PAIR4: idx0 = {28'd0, texel[3:0]};
            MODE_IDX8:  idx0 = {24'd0, texel[7:0]};
            MODE_IDX16: idx0 = {16'd0, texel[15:0]};
            default:    idx0 = texel;
        endcase
        idx1 = {28'd0, texel[7:4]};
    end

    always_comb
    begin
        push_entry.fmt   = fmt_reg;
        push_entry.wdata = wdata;
        if (s_axis_tuser)
        begin
            push_entry.kind       = OP_WRITE;
            push_entry.first.addr = waddr;
            push_entry.first.hi   = 1'b0;
            push_entry.first.ok   = in_store(waddr);
        end
        else
        begin
            push_entry.kind  = (mode_reg == MODE_PAIR4) ? OP_PAIR : OP_SINGLE;
            push_entry.first = make_lookup(idx0, start_reg, shift_reg, mask_reg, fmt_reg);
        end
        push_entry.second = make_lookup(idx1, start_reg, shift_reg, mask_reg, fmt_reg);
    end

    assign s_axis_tready = push_ready;
    assign push          = s_axis_tvalid && push_ready;

endmodule

@@ rtl/ptd_queue.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ptd_queue
    import ptd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   push_ready,
    output logic   head_valid,
    output entry_t head_entry,
    input  logic   pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t           slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    `ASSERT_CLK(a_count_bounded, clk, rst_n, count_reg <= CNT_W'(DEPTH))
    `ASSERT_CLK(a_pop_nonempty, clk, rst_n, pop |-> count_reg != '0)

endmodule

@@ rtl/ptd_back.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ptd_back
    import ptd_pkg::*;
#(
    parameter int PALETTE_WORDS = PALETTE_WORDS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  entry_t                head_entry,
    output logic                  pop,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    localparam int ADDR_W = $clog2(PALETTE_WORDS);

    typedef struct packed {
        fmt_t fmt;
        logic hi;
        logic ok;
        logic last;
    } read_meta_t;

    logic              second_reg, second_next;
    logic              rd_valid_reg, rd_valid_next;
    read_meta_t        meta_reg, meta_next;
    logic              out_valid_reg, out_valid_next;
    logic [31:0]       out_data_reg;
    logic              out_last_reg;

    logic              rd_advance;
    logic              issue_ok;
    logic              ram_we;
    logic              ram_re;
    lookup_t           rd_lookup;
    logic [31:0]       ram_rdata;
    logic [31:0]       word;
    logic [15:0]       half;
    logic [31:0]       color;

    ptd_ram #(
        .WIDTH (32),
        .DEPTH (PALETTE_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(head_entry.first.addr)),
        .wdata (head_entry.wdata),
        .re    (ram_re),
        .raddr (ADDR_W'(rd_lookup.addr)),
        .rdata (ram_rdata)
    );

    assign rd_advance = rd_valid_reg && (!out_valid_reg || m_axis_tready);
    assign issue_ok   = !rd_valid_reg || rd_advance;

    always_comb
    begin
        pop         = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        second_next = second_reg;
        rd_lookup   = head_entry.first;
        meta_next   = meta_reg;
        if (head_valid)
        begin
            case (head_entry.kind)
                OP_WRITE:
                begin
                    ram_we = head_entry.first.ok;
                    pop    = 1'b1;
                end
                OP_SINGLE:
                begin
                    ram_re = issue_ok;
                    pop    = issue_ok;
                end
                OP_PAIR:
                begin
                    ram_re = issue_ok;
                    if (second_reg)
                    begin
                        rd_lookup = head_entry.second;
                        pop       = issue_ok;
                    end
                    if (issue_ok)
                    begin
                        second_next = !second_reg;
                    end
                end
                default:
                begin
                    pop = 1'b1;
                end
            endcase
        end
        if (ram_re)
        begin
            meta_next.fmt  = head_entry.fmt;
            meta_next.hi   = rd_lookup.hi;
            meta_next.ok   = rd_lookup.ok;
            meta_next.last = (head_entry.kind != OP_PAIR) || second_reg;
        end
        rd_valid_next = ram_re ? 1'b1 : (rd_advance ? 1'b0 : rd_valid_reg);
        out_valid_next = rd_advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
    end

    // Entries past the store end read as a zero word
    always_comb
    begin
        word  = meta_reg.ok ? ram_rdata : 32'd0;
        half  = meta_reg.hi ? word[31:16] : word[15:0];
        color = (meta_reg.fmt == FMT_RAW) ? word : expand(half, meta_reg.fmt);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_reg    <= 1'b0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            second_reg    <= second_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        meta_reg <= meta_next;
        if (rd_advance)
        begin
            out_data_reg <= color;
            out_last_reg <= meta_reg.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    `ASSERT_CLK(a_second_on_pair, clk, rst_n, second_reg |-> head_valid && head_entry.kind == OP_PAIR)
    `ASSERT_CLK(a_read_held, clk, rst_n, (rd_valid_reg && !rd_advance) |=> rd_valid_reg)
    `ASSERT_NEVER(a_one_ram_op, clk, rst_n, ram_we && ram_re)

endmodule
